// ===== sv/i2c_bit_level_master_top_assert.svh =====
// ----------------------------------------------------------------------------
// I2C bit-level master assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_TOP_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_ASSERT_SVH

// Same-cycle implication
`define I2CBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define I2CBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Command codes, sequencer modes, register indexes and phase tables.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Command codes carried by op
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    // Register reset values
    localparam logic [15:0] HALF_PERIOD_RST = 16'd10;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

    // Sub-step of a write bit cell
    localparam logic [1:0] WR_SET_SDA  = 2'd0;
    localparam logic [1:0] WR_SCL_HIGH = 2'd1;
    localparam logic [1:0] WR_SCL_LOW  = 2'd2;

    // Sequencer mode
    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_START = 6'b000010,
        MODE_STOP  = 6'b000100,
        MODE_WRITE = 6'b001000,
        MODE_WAIT  = 6'b010000,
        MODE_READ  = 6'b100000
    } mode_t;

    // Map a command code to its mode
    function automatic mode_t op_to_mode(input logic [2:0] code);
        mode_t m;
        unique case (code)
            OP_START: m = MODE_START;
            OP_STOP:  m = MODE_STOP;
            OP_WRITE: m = MODE_WRITE;
            OP_WAIT:  m = MODE_WAIT;
            OP_READ:  m = MODE_READ;
            default:  m = MODE_IDLE;
        endcase
        return m;
    endfunction

    // Number of phases of each command
    function automatic logic [4:0] phase_total(input mode_t m);
        logic [4:0] n;
        unique case (m)
            MODE_START: n = 5'd4;
            MODE_STOP:  n = 5'd3;
            MODE_WRITE: n = 5'd25;
            MODE_WAIT:  n = 5'd1;
            MODE_READ:  n = 5'd20;
            default:    n = 5'd1;
        endcase
        return n;
    endfunction

    // Sub-step of a write phase, phases 1 to 24 form eight three-step bit cells
    function automatic logic [1:0] wr_sub(input logic [4:0] idx);
        logic [1:0] k;
        unique case (idx)
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: k = WR_SET_SDA;
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23: k = WR_SCL_HIGH;
            default:                                              k = WR_SCL_LOW;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/i2c_bit_level_master_top.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master
// Steps SCL/SDA phase sequences for start, stop, write, wait-ack and read.
// ----------------------------------------------------------------------------
// Each request is one bus tick and the block takes one request every clock
// cycle while in_stall is low. A tick is worked out by the sequencer logic
// in the cycle it is taken, and its result (line levels, busy, done, read
// byte, ack failure) sits in an output register from the next cycle. The
// only limit on rate is the result register: while a result waits and
// out_stall is high, in_stall is high too; otherwise requests flow one per
// cycle. Configuration registers are written through a separate port that
// is always ready; a new value takes effect at the next phase load.
`include "i2c_bit_level_master_top_assert.svh"

module i2c_bit_level_master_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // tick requests
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      op,
    input  logic [7:0]                      write_byte,
    input  logic                            send_ack,
    input  logic                            sda_sample,
    // results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            scl_level,
    output logic                            sda_level,
    output logic                            busy_res,
    output logic                            done_res,
    output logic [7:0]                      read_byte,
    output logic                            ack_failed,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);

    // Configuration registers
    logic [15:0] half_reg;
    logic [15:0] tmo_cfg_reg;

    // Sequencer state
    i2cbm_pkg::mode_t mode_reg, mode_next;
    logic [4:0]  phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tmo_reg, tmo_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_reg, ack_next;
    logic        fail_reg, fail_next;
    logic [7:0]  rd_reg, rd_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;

    // Working values
    logic        accept;
    logic [15:0] hold;
    logic [15:0] dly;
    logic [4:0]  pidx;
    logic        enter_en;
    logic [4:0]  enter_idx;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign hold      = (half_reg == 16'd0) ? 16'd1 : half_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= i2cbm_pkg::HALF_PERIOD_RST;
            tmo_cfg_reg <= i2cbm_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == i2cbm_pkg::CFG_HALF_PERIOD)
            begin
                half_reg <= cfg_data;
            end
            if (cfg_index == i2cbm_pkg::CFG_ACK_TIMEOUT)
            begin
                tmo_cfg_reg <= cfg_data;
            end
        end
    end

    // Advance the sequencer by one tick
    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        delay_next   = delay_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        tmo_next     = tmo_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        ack_next     = ack_reg;
        fail_next    = fail_reg;
        rd_next      = rd_reg;
        done_next    = done_reg;
        enter_en     = 1'b0;
        enter_idx    = 5'd0;
        pidx         = phase_reg + 5'd1;
        dly          = (delay_reg != 16'd0) ? delay_reg - 16'd1 : delay_reg;

        if (accept)
        begin
            done_next = 1'b0;
            priority if (mode_reg == i2cbm_pkg::MODE_IDLE)
            begin
                // Load a new command
                if (op >= i2cbm_pkg::OP_START && op <= i2cbm_pkg::OP_READ)
                begin
                    mode_next    = i2cbm_pkg::op_to_mode(op);
                    phase_next   = 5'd0;
                    bit_cnt_next = 4'd0;
                    shift_next   = (op == i2cbm_pkg::OP_WRITE) ? write_byte : 8'd0;
                    ack_next     = send_ack;
                    delay_next   = hold;
                    enter_en     = 1'b1;
                    enter_idx    = 5'd0;
                end
            end
            else if (mode_reg == i2cbm_pkg::MODE_WAIT && phase_reg == 5'd1)
            begin
                // Poll for acknowledge
                if (!sda_sample)
                begin
                    scl_next   = 1'b0;
                    fail_next  = 1'b0;
                    mode_next  = i2cbm_pkg::MODE_IDLE;
                    phase_next = 5'd0;
                    done_next  = 1'b1;
                end
                else if (tmo_reg == 16'd0)
                begin
                    fail_next  = 1'b1;
                    mode_next  = i2cbm_pkg::MODE_IDLE;
                    phase_next = 5'd0;
                    done_next  = 1'b1;
                end
                else
                begin
                    tmo_next = tmo_reg - 16'd1;
                end
            end
            else
            begin
                // Count down the phase hold, then leave and enter phases
                delay_next = dly;
                if (dly == 16'd0)
                begin
                    if (mode_reg == i2cbm_pkg::MODE_READ && phase_reg < 5'd16
                        && !phase_reg[0])
                    begin
                        shift_next   = {shift_reg[6:0], sda_sample};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                    end
                    phase_next = pidx;
                    if (pidx < i2cbm_pkg::phase_total(mode_reg))
                    begin
                        enter_en   = 1'b1;
                        enter_idx  = pidx;
                        delay_next = hold;
                    end
                    else if (mode_reg == i2cbm_pkg::MODE_WAIT)
                    begin
                        scl_next   = 1'b1;
                        tmo_next   = tmo_cfg_reg;
                        phase_next = 5'd1;
                    end
                    else
                    begin
                        if (mode_reg == i2cbm_pkg::MODE_READ)
                        begin
                            rd_next = shift_next;
                        end
                        mode_next  = i2cbm_pkg::MODE_IDLE;
                        phase_next = 5'd0;
                        done_next  = 1'b1;
                    end
                end
            end
        end

        // Drive the lines for the phase being entered
        if (enter_en)
        begin
            unique case (mode_next)
                i2cbm_pkg::MODE_START:
                begin
                    priority if (enter_idx == 5'd0) sda_next = 1'b1;
                    else if (enter_idx == 5'd1)     scl_next = 1'b1;
                    else if (enter_idx == 5'd2)     sda_next = 1'b0;
                    else                            scl_next = 1'b0;
                end
                i2cbm_pkg::MODE_STOP:
                begin
                    priority if (enter_idx == 5'd0)
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    else if (enter_idx == 5'd1) scl_next = 1'b1;
                    else                        sda_next = 1'b1;
                end
                i2cbm_pkg::MODE_WRITE:
                begin
                    if (enter_idx == 5'd0)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        unique case (i2cbm_pkg::wr_sub(enter_idx))
                            i2cbm_pkg::WR_SET_SDA:
                            begin
                                sda_next   = shift_next[7];
                                shift_next = {shift_next[6:0], 1'b0};
                            end
                            i2cbm_pkg::WR_SCL_HIGH:
                            begin
                                scl_next = 1'b1;
                            end
                            default:
                            begin
                                scl_next     = 1'b0;
                                bit_cnt_next = bit_cnt_next + 4'd1;
                            end
                        endcase
                    end
                end
                i2cbm_pkg::MODE_WAIT:
                begin
                    sda_next = 1'b1;
                end
                i2cbm_pkg::MODE_READ:
                begin
                    priority if (enter_idx < 5'd16)
                    begin
                        if (!enter_idx[0])
                        begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                        end
                    end
                    else if (enter_idx == 5'd16) scl_next = 1'b0;
                    else if (enter_idx == 5'd17) sda_next = ~ack_next;
                    else if (enter_idx == 5'd18) scl_next = 1'b1;
                    else                         scl_next = 1'b0;
                end
                default:
                begin
                    scl_next = scl_next;
                end
            endcase
        end
    end

    // Hold a result until it is taken, load the next on each request
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= i2cbm_pkg::MODE_IDLE;
            phase_reg     <= 5'd0;
            delay_reg     <= 16'd0;
            bit_cnt_reg   <= 4'd0;
            shift_reg     <= 8'd0;
            tmo_reg       <= 16'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            fail_reg      <= 1'b0;
            rd_reg        <= 8'd0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            delay_reg     <= delay_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            tmo_reg       <= tmo_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            fail_reg      <= fail_next;
            rd_reg        <= rd_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result ports
    assign out_valid  = out_valid_reg;
    assign scl_level  = scl_reg;
    assign sda_level  = sda_reg;
    assign busy_res   = (mode_reg != i2cbm_pkg::MODE_IDLE);
    assign done_res   = done_reg;
    assign read_byte  = rd_reg;
    assign ack_failed = fail_reg;

    // Checks
    `I2CBM_ASSERT_NOW(a_bit_cnt_range, 1'b1, bit_cnt_reg <= 4'd8,
        "bit counter ran past one byte")
    `I2CBM_ASSERT_NOW(a_done_idle, done_reg, mode_reg == i2cbm_pkg::MODE_IDLE,
        "done flagged while a command is still running")
    `I2CBM_ASSERT_NOW(a_poll_scl_high,
        mode_reg == i2cbm_pkg::MODE_WAIT && phase_reg == 5'd1, scl_reg,
        "SCL not released while polling for acknowledge")
    `I2CBM_ASSERT_NEXT(a_stall_holds_state, in_stall,
        $stable(mode_reg) && $stable(phase_reg) && $stable(delay_reg),
        "sequencer advanced while requests were stalled")

endmodule
